// ----- rtl/sm4_pkg.sv -----
// Shared types, constants and round helper functions for the SM4 cipher.
`timescale 1ns / 1ps
`default_nettype none

package sm4_pkg;

    localparam int ROUND_COUNT_DEF = 32;
    localparam int CFG_INDEX_W     = 8;
    localparam int CFG_DATA_W      = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HI = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LO = 8'd1;

    typedef logic [0:3][31:0] t_words;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    function automatic logic [31:0] tau(input logic [31:0] a);
        return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Byte j of CK word i is (4*i + j) * 7 modulo 256.
    function automatic logic [31:0] ck_word(input logic [7:0] i);
        logic [7:0] base;
        base = 8'(i * 8'd28);
        return {base, 8'(base + 8'd7), 8'(base + 8'd14), 8'(base + 8'd21)};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sm4_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module sm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/sm4_round.sv -----
// Shared SM4 round unit for key expansion and block rounds.
`timescale 1ns / 1ps
`default_nettype none

module sm4_round (
    input  wire logic                   i_key_mode,
    input  wire sm4_pkg::t_words        i_x,
    input  wire logic [31:0]            i_rk,
    output logic      [31:0]            o_word
);

    import sm4_pkg::*;

    logic [31:0] b;

    always_comb begin
        b = tau(i_x[1] ^ i_x[2] ^ i_x[3] ^ i_rk);
        if (i_key_mode) begin
            o_word = i_x[0] ^ b ^ rotl32(b, 13) ^ rotl32(b, 23);
        end else begin
            o_word = i_x[0] ^ b ^ rotl32(b, 2) ^ rotl32(b, 10)
                   ^ rotl32(b, 18) ^ rotl32(b, 24);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sm4_block_cipher.sv -----
// Top level of the SM4 block cipher: control, key registers and round-key RAM.
//
// Usage: write key_hi (index 0) and key_lo (index 1) through the config port.
// Each write re-expands the full key into the round-key RAM, one round key per
// cycle; busy is high meanwhile. A new write during expansion restarts it with
// the updated key; a write during a transaction is expanded once that block ends.
// A transaction is accepted when start is high and busy is low. The block then
// runs one round per cycle, each round reading one round key from the RAM
// port (forward order to encrypt, reverse order to decrypt). The result appears
// on o_result_hi/o_result_lo with o_result_valid high for exactly one cycle,
// registered after the final round. Busy falls with the strobe unless a key
// write is pending, so the next transaction may be accepted while it is shown.
// The receiver cannot stall; each result is presented once.
// Before any key write, every block yields an all-zero result.
// Reset clears the control state and the ready flag; the round-key RAM holds
// no defined contents until a key is written and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sm4_block_cipher #(
    parameter int ROUND_COUNT = sm4_pkg::ROUND_COUNT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [sm4_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [sm4_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_operation,
    input  wire logic [63:0]                     i_block_hi,
    input  wire logic [63:0]                     i_block_lo,
    output logic                                 o_result_valid,
    output logic      [63:0]                     o_result_hi,
    output logic      [63:0]                     o_result_lo
);

    import sm4_pkg::*;

    localparam int RW = $clog2(ROUND_COUNT);
    localparam logic [RW-1:0] LAST_ROUND = RW'(ROUND_COUNT - 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EXPAND = 3'b010,
        ST_CRYPT  = 3'b100
    } t_state;

    t_state      r_state, n_state;
    logic [RW-1:0] r_round, n_round;
    t_words      r_x, n_x;
    logic        r_op, n_op;
    logic        r_zero, n_zero;
    logic        r_keys_ready, n_keys_ready;
    logic        r_pending, n_pending;
    logic [63:0] r_key_hi, n_key_hi;
    logic [63:0] r_key_lo, n_key_lo;
    logic        r_valid, n_valid;
    logic [63:0] r_res_hi, n_res_hi;
    logic [63:0] r_res_lo, n_res_lo;

    logic          cfg_hit;
    logic          accept;
    logic          ram_we;
    logic [RW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;
    logic [31:0]   round_rk;
    logic [31:0]   round_out;
    t_words        key_words;

    function automatic logic [RW-1:0] rk_addr(input logic op, input logic [RW-1:0] j);
        return op ? LAST_ROUND - j : j;
    endfunction

    assign busy           = (r_state != ST_IDLE);
    assign accept         = start && !busy;
    assign cfg_hit        = i_cfg_we && (i_cfg_index == CFG_KEY_HI || i_cfg_index == CFG_KEY_LO);
    assign o_result_valid = r_valid;
    assign o_result_hi    = r_res_hi;
    assign o_result_lo    = r_res_lo;

    assign ram_raddr = (r_state == ST_CRYPT) ? rk_addr(r_op, r_round + RW'(1))
                                             : rk_addr(i_operation, '0);
    assign round_rk  = (r_state == ST_EXPAND) ? ck_word(8'(r_round)) : ram_rdata;
    assign key_words = {n_key_hi ^ {FK0, FK1}, n_key_lo ^ {FK2, FK3}};

    sm4_ram #(
        .WIDTH(32),
        .DEPTH(ROUND_COUNT)
    ) u_rk_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_round),
        .i_wdata(round_out),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    sm4_round u_round (
        .i_key_mode(r_state == ST_EXPAND),
        .i_x       (r_x),
        .i_rk      (round_rk),
        .o_word    (round_out)
    );

    always_comb begin
        n_state      = r_state;
        n_round      = r_round;
        n_x          = r_x;
        n_op         = r_op;
        n_zero       = r_zero;
        n_keys_ready = r_keys_ready;
        n_pending    = r_pending;
        n_key_hi     = r_key_hi;
        n_key_lo     = r_key_lo;
        n_valid      = 1'b0;
        n_res_hi     = r_res_hi;
        n_res_lo     = r_res_lo;
        ram_we       = 1'b0;

        if (cfg_hit) begin
            if (i_cfg_index == CFG_KEY_HI) begin
                n_key_hi = i_cfg_data;
            end else begin
                n_key_lo = i_cfg_data;
            end
            n_keys_ready = 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_x       = {i_block_hi, i_block_lo};
                    n_op      = i_operation;
                    n_zero    = !r_keys_ready;
                    n_round   = '0;
                    n_state   = ST_CRYPT;
                    n_pending = cfg_hit;
                end else if (cfg_hit) begin
                    n_x     = key_words;
                    n_round = '0;
                    n_state = ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                ram_we  = 1'b1;
                n_x     = {r_x[1], r_x[2], r_x[3], round_out};
                n_round = r_round + RW'(1);
                if (r_round == LAST_ROUND) begin
                    n_state = ST_IDLE;
                end
                if (cfg_hit) begin
                    n_x     = key_words;
                    n_round = '0;
                    n_state = ST_EXPAND;
                end
            end
            ST_CRYPT: begin
                n_x     = {r_x[1], r_x[2], r_x[3], round_out};
                n_round = r_round + RW'(1);
                if (cfg_hit) begin
                    n_pending = 1'b1;
                end
                if (r_round == LAST_ROUND) begin
                    n_valid  = 1'b1;
                    n_res_hi = r_zero ? '0 : {round_out, r_x[3]};
                    n_res_lo = r_zero ? '0 : {r_x[2], r_x[1]};
                    if (r_pending || cfg_hit) begin
                        n_x       = key_words;
                        n_round   = '0;
                        n_pending = 1'b0;
                        n_state   = ST_EXPAND;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_round      <= '0;
            r_keys_ready <= 1'b0;
            r_pending    <= 1'b0;
            r_valid      <= 1'b0;
            r_key_hi     <= '0;
            r_key_lo     <= '0;
        end else begin
            r_state      <= n_state;
            r_round      <= n_round;
            r_keys_ready <= n_keys_ready;
            r_pending    <= n_pending;
            r_valid      <= n_valid;
            r_key_hi     <= n_key_hi;
            r_key_lo     <= n_key_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_op     <= n_op;
        r_zero   <= n_zero;
        r_res_hi <= n_res_hi;
        r_res_lo <= n_res_lo;
    end

`ifndef NO_ASSERTIONS
    a_accept_starts_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_CRYPT)
        else $error("Accepted transaction did not start the rounds.");

    a_result_after_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == ST_CRYPT && r_round == LAST_ROUND))
        else $error("Result strobe without a completed final round.");

    a_key_write_expands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit && r_state == ST_IDLE && !start |=> r_state == ST_EXPAND && r_round == '0)
        else $error("Key write did not start key expansion.");
`endif

endmodule

`default_nettype wire
